/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands included by urb_datapath
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is asserted
`define URB_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds through reset
`define URB_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/urb_pkg.sv */
// ----------------------------------------------------------------------------
// urb_pkg
// types and constants of the uart ring buffer block
// ----------------------------------------------------------------------------
package urb_pkg;

    typedef enum logic [1:0] {
        CMD_RX         = 2'd0,
        CMD_TX_READY   = 2'd1,
        CMD_HOST_WRITE = 2'd2,
        CMD_HOST_READ  = 2'd3
    } cmd_t;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_PUSH_LF,
        ST_RD_WAIT,
        ST_RESP
    } state_t;

    typedef enum logic [1:0] {
        TX_SRC_DATA,
        TX_SRC_CR,
        TX_SRC_LF
    } tx_src_t;

    // controller to datapath
    typedef struct packed {
        logic    capture;
        logic    clr_result;
        logic    rx_push;
        logic    rx_pop;
        logic    tx_push;
        tx_src_t tx_src;
        logic    tx_pop;
        logic    irq_set;
        logic    irq_clr;
        logic    set_ovf;
        logic    set_valid;
        logic    load_byte;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        cmd_t cmd;
        logic is_lf;
        logic rx_full;
        logic rx_empty;
        logic tx_empty;
        logic tx_room1;
        logic tx_room2;
    } status_t;

endpackage

/* rtl/urb_ctrl.sv */
// ----------------------------------------------------------------------------
// urb_ctrl
// sequencer that runs one command beat through the ring datapath
// ----------------------------------------------------------------------------
module urb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  urb_pkg::status_t status,
    output urb_pkg::ctrl_t   ctrl,
    output logic             busy,
    output logic             done
);

    urb_pkg::state_t state_reg;
    urb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= urb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.tx_src = urb_pkg::TX_SRC_DATA;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            urb_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.capture    = 1'b1;
                    ctrl.clr_result = 1'b1;
                    state_next      = urb_pkg::ST_EXEC;
                end
            end
            urb_pkg::ST_EXEC:
            begin
                state_next = urb_pkg::ST_RESP;
                case (status.cmd)
                    urb_pkg::CMD_RX:
                    begin
                        if (!status.rx_full)
                        begin
                            ctrl.rx_push = 1'b1;
                        end
                        else
                        begin
                            ctrl.set_ovf = 1'b1;
                        end
                    end
                    urb_pkg::CMD_TX_READY:
                    begin
                        if (status.tx_empty)
                        begin
                            ctrl.irq_clr = 1'b1;
                        end
                        else
                        begin
                            ctrl.tx_pop    = 1'b1;
                            ctrl.set_valid = 1'b1;
                            state_next     = urb_pkg::ST_RD_WAIT;
                        end
                    end
                    urb_pkg::CMD_HOST_WRITE:
                    begin
                        ctrl.irq_set = 1'b1;
                        if (status.is_lf)
                        begin
                            // line feed goes out as cr then lf, both or neither
                            if (status.tx_room2)
                            begin
                                ctrl.tx_push = 1'b1;
                                ctrl.tx_src  = urb_pkg::TX_SRC_CR;
                                state_next   = urb_pkg::ST_PUSH_LF;
                            end
                            else
                            begin
                                ctrl.set_ovf = 1'b1;
                            end
                        end
                        else if (status.tx_room1)
                        begin
                            ctrl.tx_push = 1'b1;
                        end
                        else
                        begin
                            ctrl.set_ovf = 1'b1;
                        end
                    end
                    urb_pkg::CMD_HOST_READ:
                    begin
                        if (!status.rx_empty)
                        begin
                            ctrl.rx_pop    = 1'b1;
                            ctrl.set_valid = 1'b1;
                            state_next     = urb_pkg::ST_RD_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = urb_pkg::ST_RESP;
                    end
                endcase
            end
            urb_pkg::ST_PUSH_LF:
            begin
                ctrl.tx_push = 1'b1;
                ctrl.tx_src  = urb_pkg::TX_SRC_LF;
                state_next   = urb_pkg::ST_RESP;
            end
            urb_pkg::ST_RD_WAIT:
            begin
                ctrl.load_byte = 1'b1;
                state_next     = urb_pkg::ST_RESP;
            end
            urb_pkg::ST_RESP:
            begin
                done       = 1'b1;
                state_next = urb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = urb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/urb_datapath.sv */
// ----------------------------------------------------------------------------
// urb_datapath
// receive and transmit rings with their pointers, fill counts and result
// registers
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module urb_datapath
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       command,
    input  logic [7:0]       data_byte,
    input  urb_pkg::ctrl_t   ctrl,
    output urb_pkg::status_t status,
    output logic [7:0]       out_byte,
    output logic             out_valid,
    output logic             tx_irq_enable,
    output logic             overflow,
    output logic [8:0]       rx_level,
    output logic [8:0]       tx_level
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam logic [PW-1:0] LAST_POS  = PW'(RING_DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(RING_DEPTH);
    localparam logic [FW-1:0] TWO_SHORT = FW'(RING_DEPTH - 2);

    logic [7:0] rx_mem [RING_DEPTH];
    logic [7:0] tx_mem [RING_DEPTH];

    urb_pkg::cmd_t cmd_reg;
    logic [7:0]    data_reg;
    logic [PW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [PW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [FW-1:0] rx_fill_reg, rx_fill_next, tx_fill_reg, tx_fill_next;
    logic          irq_reg, irq_next;
    logic [7:0]    rx_rd_reg, tx_rd_reg;
    logic [7:0]    byte_reg, byte_next;
    logic          valid_reg, valid_next;
    logic          ovf_reg, ovf_next;
    logic [7:0]    tx_wr_byte;
    logic [FW+8:0] rx_wide, tx_wide;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] pos);
        advance = (pos == LAST_POS) ? '0 : pos + 1'b1;
    endfunction

    // command beat capture
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg  <= urb_pkg::cmd_t'(command);
            data_reg <= data_byte;
        end
    end

    always_comb
    begin
        case (ctrl.tx_src)
            urb_pkg::TX_SRC_CR: tx_wr_byte = urb_pkg::BYTE_CR;
            urb_pkg::TX_SRC_LF: tx_wr_byte = urb_pkg::BYTE_LF;
            default:            tx_wr_byte = data_reg;
        endcase
    end

    // ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.rx_push)
        begin
            rx_mem[rx_tail_reg] <= data_reg;
        end
        if (ctrl.rx_pop)
        begin
            rx_rd_reg <= rx_mem[rx_head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.tx_push)
        begin
            tx_mem[tx_tail_reg] <= tx_wr_byte;
        end
        if (ctrl.tx_pop)
        begin
            tx_rd_reg <= tx_mem[tx_head_reg];
        end
    end

    always_comb
    begin
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        rx_fill_next = rx_fill_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        tx_fill_next = tx_fill_reg;
        irq_next     = irq_reg;
        byte_next    = byte_reg;
        valid_next   = valid_reg;
        ovf_next     = ovf_reg;
        if (ctrl.rx_push)
        begin
            rx_tail_next = advance(rx_tail_reg);
            rx_fill_next = rx_fill_reg + 1'b1;
        end
        if (ctrl.rx_pop)
        begin
            rx_head_next = advance(rx_head_reg);
            rx_fill_next = rx_fill_reg - 1'b1;
        end
        if (ctrl.tx_push)
        begin
            tx_tail_next = advance(tx_tail_reg);
            tx_fill_next = tx_fill_reg + 1'b1;
        end
        if (ctrl.tx_pop)
        begin
            tx_head_next = advance(tx_head_reg);
            tx_fill_next = tx_fill_reg - 1'b1;
        end
        if (ctrl.irq_set)
        begin
            irq_next = 1'b1;
        end
        if (ctrl.irq_clr)
        begin
            irq_next = 1'b0;
        end
        if (ctrl.clr_result)
        begin
            byte_next  = '0;
            valid_next = 1'b0;
            ovf_next   = 1'b0;
        end
        if (ctrl.set_ovf)
        begin
            ovf_next = 1'b1;
        end
        if (ctrl.set_valid)
        begin
            valid_next = 1'b1;
        end
        if (ctrl.load_byte)
        begin
            byte_next = (cmd_reg == urb_pkg::CMD_HOST_READ) ? rx_rd_reg : tx_rd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            rx_fill_reg <= '0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            tx_fill_reg <= '0;
            irq_reg     <= 1'b0;
            valid_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            rx_fill_reg <= rx_fill_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            tx_fill_reg <= tx_fill_next;
            irq_reg     <= irq_next;
            valid_reg   <= valid_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    always_comb
    begin
        status.cmd      = cmd_reg;
        status.is_lf    = (data_reg == urb_pkg::BYTE_LF);
        status.rx_full  = (rx_fill_reg == FULL_FILL);
        status.rx_empty = (rx_fill_reg == '0);
        status.tx_empty = (tx_fill_reg == '0);
        status.tx_room1 = (tx_fill_reg != FULL_FILL);
        status.tx_room2 = (tx_fill_reg <= TWO_SHORT);
    end

    // levels report the count modulo 512
    assign rx_wide       = {9'b0, rx_fill_reg};
    assign tx_wide       = {9'b0, tx_fill_reg};
    assign rx_level      = rx_wide[8:0];
    assign tx_level      = tx_wide[8:0];
    assign out_byte      = byte_reg;
    assign out_valid     = valid_reg;
    assign tx_irq_enable = irq_reg;
    assign overflow      = ovf_reg;

    `URB_ASSERT_RST(a_rx_push_count, clk, rst_n, ctrl.rx_push |=> rx_fill_reg == $past(rx_fill_reg) + 1'b1, "rx fill did not count a push")
    `URB_ASSERT_RST(a_tx_pop_nonempty, clk, rst_n, ctrl.tx_pop |-> tx_fill_reg != '0, "pop from empty transmit ring")
    `URB_ASSERT(a_load_after_pop, clk, ctrl.load_byte |-> $past(ctrl.rx_pop || ctrl.tx_pop), "byte load without a prior ring read")

endmodule

/* rtl/uart_ring_buffer_crlf_top.sv */
// ----------------------------------------------------------------------------
// uart_ring_buffer_crlf_top
// uart receive and transmit byte rings with lf to cr-lf expansion
// ----------------------------------------------------------------------------
// usage:
//   a command beat (command, data_byte) is taken at a clock edge with start
//   high and busy low. command 0 pushes a line byte into the receive ring,
//   1 pops a byte to transmit (or drops the transmit interrupt enable when
//   the ring is empty), 2 queues a host byte (lf becomes cr, lf) and sets the
//   enable, 3 pops a received byte for the host.
//   every beat gives one result, shown for a single cycle with done high:
//   out_byte, out_valid, tx_irq_enable, overflow, rx_level, tx_level.
//   after the accepting edge a beat passes through exec and then resp, where
//   done is high; a pop adds rd_wait (registered ring read) and a line feed
//   write adds push_lf (second ring write on the single write port) before
//   resp. busy drops the cycle after done.
//   reset clears the pointers, fill counts and the interrupt enable; ring
//   storage is not cleared and needs no clearing pass.
//   the receiver cannot stall: done is one cycle and is never held.
// ----------------------------------------------------------------------------
module uart_ring_buffer_crlf_top
#(
    parameter int RING_DEPTH = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] command,
    input  logic [7:0] data_byte,
    output logic       done,
    output logic [7:0] out_byte,
    output logic       out_valid,
    output logic       tx_irq_enable,
    output logic       overflow,
    output logic [8:0] rx_level,
    output logic [8:0] tx_level
);

    urb_pkg::ctrl_t   ctrl;
    urb_pkg::status_t status;

    urb_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy),
        .done   (done)
    );

    urb_datapath
    #(
        .RING_DEPTH (RING_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .command       (command),
        .data_byte     (data_byte),
        .ctrl          (ctrl),
        .status        (status),
        .out_byte      (out_byte),
        .out_valid     (out_valid),
        .tx_irq_enable (tx_irq_enable),
        .overflow      (overflow),
        .rx_level      (rx_level),
        .tx_level      (tx_level)
    );

endmodule

/* bench/uart_ring_buffer_crlf_top_test.sv */
// ----------------------------------------------------------------------------
// uart_ring_buffer_crlf_top_test
// self-checking bench for the uart receive / transmit byte rings
// ----------------------------------------------------------------------------
// a short directed run hits empty pops, extreme bytes, the cr-lf expansion
// and the enable clearing on an empty ready tick. random traffic then runs
// in phases that fill the receive ring, fill the transmit ring, drain both,
// or mix freely, so full rings, dropped pushes and pointer wrap all occur.
// every command beat is predicted by a small ring model and each done beat
// is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module uart_ring_buffer_crlf_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH     = 256;
    localparam int RANDOM_BEATS   = 900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        MODE_FILL_RX,
        MODE_FILL_TX,
        MODE_DRAIN,
        MODE_MIXED
    } traffic_mode_t;

    typedef struct {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       irq_en;
        logic       dropped;
        logic [8:0] rx_count;
        logic [8:0] tx_count;
    } ring_result_t;

    // ring model plus the list of results it still waits for
    class uart_ring_predictor;
        logic [7:0]   rx_ring[$];
        logic [7:0]   tx_ring[$];
        bit           irq_on;
        ring_result_t pending_results[$];
        int           errors;
        int           beats;
        int           checked;
        int           drops;
        int           lf_pairs;
        int           peak_rx;
        int           peak_tx;

        function void note_command(urb_pkg::cmd_t cmd, logic [7:0] data);
            ring_result_t r;
            r.out_byte  = 8'h00;
            r.out_valid = 1'b0;
            r.dropped   = 1'b0;
            case (cmd)
                urb_pkg::CMD_RX:
                begin
                    if (rx_ring.size() < RING_DEPTH)
                        rx_ring.push_back(data);
                    else
                        r.dropped = 1'b1;
                end
                urb_pkg::CMD_TX_READY:
                begin
                    if (tx_ring.size() == 0)
                        irq_on = 1'b0;
                    else
                    begin
                        r.out_byte  = tx_ring.pop_front();
                        r.out_valid = 1'b1;
                    end
                end
                urb_pkg::CMD_HOST_WRITE:
                begin
                    // line feed goes out as a cr, lf pair or not at all
                    if (data == urb_pkg::BYTE_LF)
                    begin
                        if (RING_DEPTH - tx_ring.size() >= 2)
                        begin
                            tx_ring.push_back(urb_pkg::BYTE_CR);
                            tx_ring.push_back(urb_pkg::BYTE_LF);
                            lf_pairs++;
                        end
                        else
                            r.dropped = 1'b1;
                    end
                    else if (tx_ring.size() < RING_DEPTH)
                        tx_ring.push_back(data);
                    else
                        r.dropped = 1'b1;
                    irq_on = 1'b1;
                end
                default:
                begin
                    if (rx_ring.size() != 0)
                    begin
                        r.out_byte  = rx_ring.pop_front();
                        r.out_valid = 1'b1;
                    end
                end
            endcase
            r.irq_en   = irq_on;
            r.rx_count = 9'(rx_ring.size());
            r.tx_count = 9'(tx_ring.size());
            if (r.dropped)
                drops++;
            if (rx_ring.size() > peak_rx)
                peak_rx = rx_ring.size();
            if (tx_ring.size() > peak_tx)
                peak_tx = tx_ring.size();
            beats++;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [8:0] exp, logic [8:0] act);
            if (act !== exp)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(ring_result_t act);
            ring_result_t exp;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, out_byte %0h", $time, act.out_byte);
                errors++;
                return;
            end
            exp = pending_results.pop_front();
            checked++;
            compare_field("out_byte", 9'(exp.out_byte), 9'(act.out_byte));
            compare_field("out_valid", 9'(exp.out_valid), 9'(act.out_valid));
            compare_field("tx_irq_enable", 9'(exp.irq_en), 9'(act.irq_en));
            compare_field("overflow", 9'(exp.dropped), 9'(act.dropped));
            compare_field("rx_level", exp.rx_count, act.rx_count);
            compare_field("tx_level", exp.tx_count, act.tx_count);
        endfunction
    endclass

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [1:0] command   = urb_pkg::CMD_RX;
    logic [7:0] data_byte = 8'h00;
    logic       busy;
    logic       done;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       tx_irq_enable;
    logic       overflow;
    logic [8:0] rx_level;
    logic [8:0] tx_level;

    uart_ring_predictor ring_model = new;
    int                 stall_cycles = 0;

    uart_ring_buffer_crlf_top #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .data_byte(data_byte),
        .done(done),
        .out_byte(out_byte),
        .out_valid(out_valid),
        .tx_irq_enable(tx_irq_enable),
        .overflow(overflow),
        .rx_level(rx_level),
        .tx_level(tx_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: done lasts one cycle and cannot be held off
    always @(posedge clk)
    begin
        ring_result_t act;
        if (rst_n && done)
        begin
            act.out_byte  = out_byte;
            act.out_valid = out_valid;
            act.irq_en    = tx_irq_enable;
            act.dropped   = overflow;
            act.rx_count  = rx_level;
            act.tx_count  = tx_level;
            ring_model.check_result(act);
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void pick_beat(traffic_mode_t mode, output urb_pkg::cmd_t cmd,
                                      output logic [7:0] data);
        int r;
        r    = $urandom_range(0, 99);
        cmd  = urb_pkg::cmd_t'($urandom_range(0, 3));
        data = 8'($urandom_range(0, 255));
        case (mode)
            MODE_FILL_RX:
                if (r < 95)
                    cmd = urb_pkg::CMD_RX;
            MODE_FILL_TX:
            begin
                if (r < 95)
                    cmd = urb_pkg::CMD_HOST_WRITE;
                if ($urandom_range(0, 9) < 3)
                    data = urb_pkg::BYTE_LF;
            end
            MODE_DRAIN:
            begin
                if (r < 45)
                    cmd = urb_pkg::CMD_TX_READY;
                else if (r < 90)
                    cmd = urb_pkg::CMD_HOST_READ;
            end
            default:
                if ($urandom_range(0, 7) == 0)
                    data = urb_pkg::BYTE_LF;
        endcase
    endfunction

    // start stays high across back-to-back beats; this task lowers it only for a gap
    task automatic issue_beat(urb_pkg::cmd_t cmd, logic [7:0] data, bit no_gap);
        int gap;
        start     <= 1'b1;
        command   <= cmd;
        data_byte <= data;
        do
            @(posedge clk);
        while (busy);
        ring_model.note_command(cmd, data);
        gap = no_gap ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (ring_model.pending_results.size() != 0);
    endtask

    initial
    begin
        traffic_mode_t mode;
        urb_pkg::cmd_t cmd;
        logic [7:0]    data;
        int            sent;
        int            phase;
        int            span;
        bit            burst;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty rings, extreme bytes, cr-lf expansion, enable clearing
        issue_beat(urb_pkg::CMD_TX_READY, 8'hFF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_READ, 8'hA5, 1'b0);
        issue_beat(urb_pkg::CMD_RX, 8'h00, 1'b0);
        issue_beat(urb_pkg::CMD_RX, 8'hFF, 1'b0);
        issue_beat(urb_pkg::CMD_RX, urb_pkg::BYTE_LF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_READ, 8'hFF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, 8'hFF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, 8'h00, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, urb_pkg::BYTE_LF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, urb_pkg::BYTE_CR, 1'b0);
        issue_beat(urb_pkg::CMD_TX_READY, 8'h5A, 1'b0);
        repeat (4) issue_beat(urb_pkg::CMD_TX_READY, 8'h00, 1'b1);
        issue_beat(urb_pkg::CMD_TX_READY, 8'h00, 1'b0);
        issue_beat(urb_pkg::CMD_TX_READY, 8'hC3, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, 8'h55, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_WRITE, 8'hAA, 1'b1);
        issue_beat(urb_pkg::CMD_TX_READY, 8'h3C, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_READ, 8'h00, 1'b1);
        issue_beat(urb_pkg::CMD_HOST_READ, 8'hFF, 1'b0);
        issue_beat(urb_pkg::CMD_HOST_READ, 8'h00, 1'b0);
        wait_drained();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BEATS)
        begin
            mode = traffic_mode_t'(phase % 4);
            case (mode)
                MODE_FILL_RX, MODE_FILL_TX: span = $urandom_range(260, 320);
                MODE_DRAIN:                 span = $urandom_range(250, 320);
                default:                    span = $urandom_range(40, 120);
            endcase
            burst = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span && sent < RANDOM_BEATS; i++)
            begin
                pick_beat(mode, cmd, data);
                issue_beat(cmd, data, burst);
                sent++;
            end
            if ($urandom_range(0, 1) == 1)
                wait_drained();
            phase++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (ring_model.pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time,
                     ring_model.pending_results.size());
            ring_model.errors++;
        end
        $display("ran %0d command beats (%0d checked): %0d lf pairs queued, %0d pushes dropped",
                 ring_model.beats, ring_model.checked, ring_model.lf_pairs, ring_model.drops);
        $display("highest fill reached: receive %0d, transmit %0d of %0d entries",
                 ring_model.peak_rx, ring_model.peak_tx, RING_DEPTH);
        if (ring_model.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
